// File: src/fac_pkg.sv
// ----------------------------------------------------------------------------
// fac_pkg
// Shared constants and types for the frustum box culling block.
// ----------------------------------------------------------------------------
package fac_pkg;

  // default field widths
  localparam int COORD_WIDTH_DEF  = 16;
  localparam int MATRIX_WIDTH_DEF = 16;

  // configuration port
  localparam int CFG_INDEX_WIDTH = 8;
  localparam int CFG_DATA_WIDTH  = 64;

  // register indexes
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_MATRIX_ROW0 = 8'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_MATRIX_ROW1 = 8'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_MATRIX_ROW2 = 8'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_MATRIX_ROW3 = 8'd3;

  // plane slots and plane coefficient columns
  localparam int NUM_PLANES   = 6;
  localparam int NUM_COLS     = 4;
  localparam int NUM_AXES     = 3;
  localparam int PLANE_LEFT   = 0;
  localparam int PLANE_RIGHT  = 1;
  localparam int PLANE_BOTTOM = 2;
  localparam int PLANE_TOP    = 3;
  localparam int PLANE_NEAR   = 4;
  localparam int PLANE_FAR    = 5;
  localparam int COL_D        = 3;

  // stage advance strobes from the pipeline control to the plane units
  typedef struct packed {
    logic adv_prod;
    logic adv_sum;
  } fac_stage_ctl_t;

endpackage

// File: src/frustum_aabb_cull.sv
// ----------------------------------------------------------------------------
// frustum_aabb_cull
// Tests axis-aligned boxes against the six planes of a view frustum taken
// from a configured view-projection matrix.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  in      | input     | in_valid / in_ready   | in_box_min_{x,y,z}, in_box_max_{x,y,z}
//  out     | output    | out_valid / out_ready | out_visible
//  cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
//  one box per cycle sustained while out_ready is high; an accepted box passes the input,
//  product, plane sum and output registers on its way to out_valid
//  cfg_ready is always high; planes follow a row write through the row and plane registers
//  synchronous active-low reset clears the rows, the planes and all valid bits
//  each stage advances when its successor is empty or moving, so bubbles collapse
//  and a stall at out_ready holds every item in place
// ----------------------------------------------------------------------------
module frustum_aabb_cull #(
  parameter int COORD_WIDTH  = fac_pkg::COORD_WIDTH_DEF,
  parameter int MATRIX_WIDTH = fac_pkg::MATRIX_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [COORD_WIDTH-1:0]       in_box_min_x,
  input  logic signed [COORD_WIDTH-1:0]       in_box_min_y,
  input  logic signed [COORD_WIDTH-1:0]       in_box_min_z,
  input  logic signed [COORD_WIDTH-1:0]       in_box_max_x,
  input  logic signed [COORD_WIDTH-1:0]       in_box_max_y,
  input  logic signed [COORD_WIDTH-1:0]       in_box_max_z,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_visible,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fac_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [fac_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);
  import fac_pkg::*;

  logic [NUM_PLANES-1:0][NUM_COLS-1:0][MATRIX_WIDTH:0] plane_coef;
  logic [NUM_AXES-1:0][COORD_WIDTH-1:0] lo_r;
  logic [NUM_AXES-1:0][COORD_WIDTH-1:0] hi_r;
  logic [NUM_PLANES-1:0]                reject;
  fac_stage_ctl_t                       ctl;

  logic v0_r, v1_r, v2_r, out_valid_r, out_visible_r;
  logic en0, en1, en2, en3;

  // configuration transactions are always taken
  assign cfg_ready = 1'b1;

  fac_planes #(
    .MATRIX_WIDTH(MATRIX_WIDTH)
  ) u_planes (
    .clk          (clk),
    .rst_n        (rst_n),
    .wr_en_i      (cfg_valid && cfg_ready),
    .wr_index_i   (cfg_index),
    .wr_data_i    (cfg_data),
    .plane_coef_o (plane_coef)
  );

  // stage advance: a stage moves when it is empty or its successor moves
  assign en3      = !out_valid_r || out_ready;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign en0      = !v0_r || en1;
  assign in_ready = en0;

  assign ctl.adv_prod = en1;
  assign ctl.adv_sum  = en2;

  // valid bits travel alongside the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en0) v0_r        <= in_valid;
      if (en1) v1_r        <= v0_r;
      if (en2) v2_r        <= v1_r;
      if (en3) out_valid_r <= v2_r;
    end
  end

  // input register for the box corners
  always_ff @(posedge clk) begin
    if (en0) begin
      lo_r <= {in_box_min_z, in_box_min_y, in_box_min_x};
      hi_r <= {in_box_max_z, in_box_max_y, in_box_max_x};
    end
  end

  // one test unit per plane
  for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
    fac_plane_test #(
      .COORD_WIDTH  (COORD_WIDTH),
      .MATRIX_WIDTH (MATRIX_WIDTH)
    ) u_test (
      .clk      (clk),
      .ctl_i    (ctl),
      .lo_i     (lo_r),
      .hi_i     (hi_r),
      .coef_i   (plane_coef[p]),
      .reject_o (reject[p])
    );
  end

  // output register: visible unless some plane rejects
  always_ff @(posedge clk) begin
    if (en3) out_visible_r <= ~(|reject);
  end

  assign out_valid   = out_valid_r;
  assign out_visible = out_visible_r;

  // a held product stage keeps its item
  a_hold_prod: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && !en2) |=> v1_r)
    else $error("product stage lost an item during a stall");

  // input only refused when the whole pipeline is full and stalled
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready && v0_r && v1_r && v2_r))
    else $error("input refused with room in the pipeline");

  // with the sink ready meanwhile, an accepted transaction reaches out_valid without stalling
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) ##1 out_ready ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("result missing after flowing latency");

endmodule

// File: src/fac_planes.sv
// ----------------------------------------------------------------------------
// fac_planes
// Matrix row registers and registered derivation of the six frustum planes.
// ----------------------------------------------------------------------------
module fac_planes #(
  parameter int MATRIX_WIDTH = fac_pkg::MATRIX_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                wr_en_i,
  input  logic [fac_pkg::CFG_INDEX_WIDTH-1:0] wr_index_i,
  input  logic [fac_pkg::CFG_DATA_WIDTH-1:0]  wr_data_i,
  output logic [fac_pkg::NUM_PLANES-1:0][fac_pkg::NUM_COLS-1:0][MATRIX_WIDTH:0] plane_coef_o
);
  import fac_pkg::*;

  localparam int ROW_WIDTH = NUM_COLS * MATRIX_WIDTH;
  localparam int CW        = MATRIX_WIDTH + 1;

  logic [3:0][ROW_WIDTH-1:0] row_r;
  logic [3:0][ROW_WIDTH-1:0] row_nxt;
  logic [NUM_PLANES-1:0][NUM_COLS-1:0][CW-1:0] plane_r;
  logic [NUM_PLANES-1:0][NUM_COLS-1:0][CW-1:0] plane_nxt;

  // register write decode, unknown indexes are dropped
  always_comb begin
    row_nxt = row_r;
    if (wr_en_i) begin
      case (wr_index_i)
        REG_MATRIX_ROW0: row_nxt[0] = wr_data_i[ROW_WIDTH-1:0];
        REG_MATRIX_ROW1: row_nxt[1] = wr_data_i[ROW_WIDTH-1:0];
        REG_MATRIX_ROW2: row_nxt[2] = wr_data_i[ROW_WIDTH-1:0];
        REG_MATRIX_ROW3: row_nxt[3] = wr_data_i[ROW_WIDTH-1:0];
        default: row_nxt = row_r;
      endcase
    end
  end

  // plane extraction: sums and differences of rows (near plane is row 2 alone), one column at a time
  always_comb begin
    logic signed [CW-1:0] r0, r1, r2, r3;
    for (int k = 0; k < NUM_COLS; k++) begin
      r0 = CW'($signed(row_r[0][k*MATRIX_WIDTH +: MATRIX_WIDTH]));
      r1 = CW'($signed(row_r[1][k*MATRIX_WIDTH +: MATRIX_WIDTH]));
      r2 = CW'($signed(row_r[2][k*MATRIX_WIDTH +: MATRIX_WIDTH]));
      r3 = CW'($signed(row_r[3][k*MATRIX_WIDTH +: MATRIX_WIDTH]));
      plane_nxt[PLANE_LEFT][k]   = r3 + r0;
      plane_nxt[PLANE_RIGHT][k]  = r3 - r0;
      plane_nxt[PLANE_BOTTOM][k] = r3 + r1;
      plane_nxt[PLANE_TOP][k]    = r3 - r1;
      plane_nxt[PLANE_NEAR][k]   = r2;
      plane_nxt[PLANE_FAR][k]    = r3 - r2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r   <= '0;
      plane_r <= '0;
    end else begin
      row_r   <= row_nxt;
      plane_r <= plane_nxt;
    end
  end

  assign plane_coef_o = plane_r;

endmodule

// File: src/fac_plane_test.sv
// ----------------------------------------------------------------------------
// fac_plane_test
// One plane against the box: positive vertex pick and products, then the
// plane sum and its sign, each behind a pipeline register.
// ----------------------------------------------------------------------------
module fac_plane_test #(
  parameter int COORD_WIDTH  = fac_pkg::COORD_WIDTH_DEF,
  parameter int MATRIX_WIDTH = fac_pkg::MATRIX_WIDTH_DEF
) (
  input  logic                                                  clk,
  input  fac_pkg::fac_stage_ctl_t                               ctl_i,
  input  logic [fac_pkg::NUM_AXES-1:0][COORD_WIDTH-1:0]         lo_i,
  input  logic [fac_pkg::NUM_AXES-1:0][COORD_WIDTH-1:0]         hi_i,
  input  logic [fac_pkg::NUM_COLS-1:0][MATRIX_WIDTH:0]          coef_i,
  output logic                                                  reject_o
);
  import fac_pkg::*;

  localparam int CW = MATRIX_WIDTH + 1;
  localparam int PW = CW + COORD_WIDTH;
  localparam int SW = PW + 2;

  logic signed [PW-1:0] prod_r   [NUM_AXES];
  logic signed [PW-1:0] prod_nxt [NUM_AXES];
  logic signed [SW-1:0] sum_nxt;
  logic                 reject_r;

  // positive vertex: max corner where the normal component is non-negative
  always_comb begin
    logic signed [COORD_WIDTH-1:0] sel;
    logic signed [CW-1:0]          nrm;
    for (int k = 0; k < NUM_AXES; k++) begin
      nrm         = $signed(coef_i[k]);
      sel         = nrm[CW-1] ? $signed(lo_i[k]) : $signed(hi_i[k]);
      prod_nxt[k] = PW'(nrm) * PW'(sel);
    end
  end

  // plane distance at the positive vertex, full width
  assign sum_nxt = SW'(prod_r[0]) + SW'(prod_r[1]) + SW'(prod_r[2])
                 + SW'($signed(coef_i[COL_D]));

  always_ff @(posedge clk) begin
    if (ctl_i.adv_prod) begin
      for (int k = 0; k < NUM_AXES; k++) prod_r[k] <= prod_nxt[k];
    end
    if (ctl_i.adv_sum) begin
      reject_r <= sum_nxt[SW-1];
    end
  end

  assign reject_o = reject_r;

endmodule

// File: bench/frustum_cull_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frustum_cull_checker
// Watches the box, result and register channels of the frustum culling
// block. It keeps its own copy of the matrix rows, works out the visibility
// of every accepted box and compares it with the results in order.
// ----------------------------------------------------------------------------
module frustum_cull_checker #(
  parameter int COORD_WIDTH  = fac_pkg::COORD_WIDTH_DEF,
  parameter int MATRIX_WIDTH = fac_pkg::MATRIX_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic signed [COORD_WIDTH-1:0]       in_box_min_x,
  input  logic signed [COORD_WIDTH-1:0]       in_box_min_y,
  input  logic signed [COORD_WIDTH-1:0]       in_box_min_z,
  input  logic signed [COORD_WIDTH-1:0]       in_box_max_x,
  input  logic signed [COORD_WIDTH-1:0]       in_box_max_y,
  input  logic signed [COORD_WIDTH-1:0]       in_box_max_z,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic                                out_visible,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [fac_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [fac_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
  output int                                  fail_count,
  output int                                  pending,
  output int                                  visible_seen,
  output int                                  culled_seen
);
  import fac_pkg::*;

  // shadow copy of the view-projection rows
  logic [CFG_DATA_WIDTH-1:0] view_rows [4];

  // visibility of boxes still in flight, oldest first
  logic visibility_q [$];
  logic expected_vis;
  int   result_idx = 0;

  // box against the six planes pulled from the matrix rows
  function automatic logic box_in_frustum(
    input logic signed [COORD_WIDTH-1:0] lo_x, lo_y, lo_z,
    input logic signed [COORD_WIDTH-1:0] hi_x, hi_y, hi_z
  );
    logic signed [MATRIX_WIDTH-1:0] field;
    longint m [4][NUM_COLS];
    longint plane [NUM_PLANES][NUM_COLS];
    longint corner_lo [NUM_AXES];
    longint corner_hi [NUM_AXES];
    longint acc;
    logic   vis;
    corner_lo[0] = lo_x;
    corner_lo[1] = lo_y;
    corner_lo[2] = lo_z;
    corner_hi[0] = hi_x;
    corner_hi[1] = hi_y;
    corner_hi[2] = hi_z;
    // signed matrix entries, column 0 in the low bits
    for (int r = 0; r < 4; r++) begin
      for (int k = 0; k < NUM_COLS; k++) begin
        field   = view_rows[r][k*MATRIX_WIDTH +: MATRIX_WIDTH];
        m[r][k] = field;
      end
    end
    // row sums and differences give the plane coefficients
    for (int k = 0; k < NUM_COLS; k++) begin
      plane[PLANE_LEFT][k]   = m[3][k] + m[0][k];
      plane[PLANE_RIGHT][k]  = m[3][k] - m[0][k];
      plane[PLANE_BOTTOM][k] = m[3][k] + m[1][k];
      plane[PLANE_TOP][k]    = m[3][k] - m[1][k];
      plane[PLANE_NEAR][k]   = m[2][k];
      plane[PLANE_FAR][k]    = m[3][k] - m[2][k];
    end
    // positive vertex per plane, zero normal component picks the max corner
    vis = 1'b1;
    for (int p = 0; p < NUM_PLANES; p++) begin
      acc = plane[p][COL_D];
      for (int k = 0; k < NUM_AXES; k++) begin
        acc += plane[p][k] * ((plane[p][k] >= 0) ? corner_hi[k] : corner_lo[k]);
      end
      if (acc < 0) begin
        vis = 1'b0;
      end
    end
    return vis;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 4; r++) begin
        view_rows[r] <= '0;
      end
      visibility_q.delete();
      pending <= 0;
    end else begin
      // register writes, unmapped indexes are dropped
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MATRIX_ROW0: view_rows[0] <= cfg_data;
          REG_MATRIX_ROW1: view_rows[1] <= cfg_data;
          REG_MATRIX_ROW2: view_rows[2] <= cfg_data;
          REG_MATRIX_ROW3: view_rows[3] <= cfg_data;
          default: ;
        endcase
      end

      // box transaction
      if (in_valid && in_ready) begin
        visibility_q.push_back(box_in_frustum(in_box_min_x, in_box_min_y, in_box_min_z,
                                              in_box_max_x, in_box_max_y, in_box_max_z));
      end

      // result transaction
      if (out_valid && out_ready) begin
        if (visibility_q.size() == 0) begin
          fail_count <= fail_count + 1;
          $display("%0t: result %0d arrived with none pending, expected none actual %0b",
                   $time, result_idx, out_visible);
        end else begin
          expected_vis = visibility_q.pop_front();
          if (out_visible !== expected_vis) begin
            fail_count <= fail_count + 1;
            $display("%0t: result %0d visible mismatch, expected %0b actual %0b",
                     $time, result_idx, expected_vis, out_visible);
          end
        end
        if (out_visible === 1'b1) begin
          visible_seen <= visible_seen + 1;
        end else begin
          culled_seen <= culled_seen + 1;
        end
        result_idx <= result_idx + 1;
      end

      pending <= visibility_q.size();
    end
  end

endmodule

// File: bench/frustum_aabb_cull_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frustum_aabb_cull_tb
// Drives boxes and matrix settings into the frustum culling block: a zero
// matrix after reset, a hand-built perspective frustum with boxes placed
// around every plane, extreme matrices and random ones, under several
// sender and receiver idling mixes. The checker does the comparing.
// ----------------------------------------------------------------------------
module frustum_aabb_cull_tb;
  import fac_pkg::*;

  localparam int CW                  = COORD_WIDTH_DEF;
  localparam int MW                  = MATRIX_WIDTH_DEF;
  localparam int CYCLE_LIMIT         = 400000;
  localparam int RANDOM_PER_SETTING  = 130;
  localparam int NUM_RANDOM_SETTINGS = 10;
  localparam int MAT_MAX             = (1 << (MW - 1)) - 1;
  localparam int MAT_MIN             = -(1 << (MW - 1));
  localparam int COORD_MAX           = (1 << (CW - 1)) - 1;
  localparam int COORD_MIN           = -(1 << (CW - 1));
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNMAPPED_FIRST = REG_MATRIX_ROW3 + 1'b1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNMAPPED_LAST  = '1;

  typedef struct packed {
    logic signed [CW-1:0] min_x;
    logic signed [CW-1:0] min_y;
    logic signed [CW-1:0] min_z;
    logic signed [CW-1:0] max_x;
    logic signed [CW-1:0] max_y;
    logic signed [CW-1:0] max_z;
  } box_t;

  logic                       clk          = 1'b0;
  logic                       rst_n        = 1'b0;
  logic                       in_valid     = 1'b0;
  logic                       in_ready;
  logic signed [CW-1:0]       in_box_min_x = '0;
  logic signed [CW-1:0]       in_box_min_y = '0;
  logic signed [CW-1:0]       in_box_min_z = '0;
  logic signed [CW-1:0]       in_box_max_x = '0;
  logic signed [CW-1:0]       in_box_max_y = '0;
  logic signed [CW-1:0]       in_box_max_z = '0;
  logic                       out_valid;
  logic                       out_ready    = 1'b0;
  logic                       out_visible;
  logic                       cfg_valid    = 1'b0;
  logic                       cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index    = '0;
  logic [CFG_DATA_WIDTH-1:0]  cfg_data     = '0;

  logic in_fire  = 1'b0;
  logic cfg_fire = 1'b0;
  int   fail_count;
  int   pending;
  int   visible_seen;
  int   culled_seen;
  int   send_idle_pct   = 0;
  int   recv_stall_pct  = 0;
  int   boxes_sent      = 0;
  int   settings_loaded = 1;
  int   cycle_count     = 0;

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  frustum_aabb_cull #(
    .COORD_WIDTH  (CW),
    .MATRIX_WIDTH (MW)
  ) u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_box_min_x (in_box_min_x),
    .in_box_min_y (in_box_min_y),
    .in_box_min_z (in_box_min_z),
    .in_box_max_x (in_box_max_x),
    .in_box_max_y (in_box_max_y),
    .in_box_max_z (in_box_max_z),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_visible  (out_visible),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  frustum_cull_checker #(
    .COORD_WIDTH  (CW),
    .MATRIX_WIDTH (MW)
  ) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_box_min_x (in_box_min_x),
    .in_box_min_y (in_box_min_y),
    .in_box_min_z (in_box_min_z),
    .in_box_max_x (in_box_max_x),
    .in_box_max_y (in_box_max_y),
    .in_box_max_z (in_box_max_z),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_visible  (out_visible),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .pending      (pending),
    .visible_seen (visible_seen),
    .culled_seen  (culled_seen)
  );

  // transaction flags from the last rising edge, read at the falling edge
  always @(posedge clk) begin
    in_fire  <= in_valid && in_ready;
    cfg_fire <= cfg_valid && cfg_ready;
  end

  // result side back-pressure
  always @(negedge clk) begin
    out_ready = (recv_stall_pct == 0) || (int'($urandom_range(99)) >= recv_stall_pct);
  end

  // run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("FAIL");
    $finish;
  end

  function automatic box_t mk_box(input int x0, y0, z0, x1, y1, z1);
    box_t b;
    b.min_x = CW'(x0);
    b.min_y = CW'(y0);
    b.min_z = CW'(z0);
    b.max_x = CW'(x1);
    b.max_y = CW'(y1);
    b.max_z = CW'(z1);
    return b;
  endfunction

  function automatic logic [CFG_DATA_WIDTH-1:0] pack_row(input int c0, c1, c2, c3);
    return {MW'(c3), MW'(c2), MW'(c1), MW'(c0)};
  endfunction

  function automatic int jitter(input int amt);
    return int'($urandom_range(2 * amt)) - amt;
  endfunction

  // mostly well-formed boxes of random size and place, some raw noise
  function automatic box_t rand_box();
    box_t b;
    int   span;
    int   c;
    int   h;
    int   lo [3];
    int   hi [3];
    int   k;
    if ($urandom_range(9) == 0) begin
      b = {$urandom, $urandom, $urandom};
      return b;
    end
    span = 1 << $urandom_range(3, CW - 1);
    for (k = 0; k < 3; k++) begin
      c     = int'($urandom_range(2 * span)) - span;
      h     = int'($urandom_range(span));
      lo[k] = (c - h < COORD_MIN) ? COORD_MIN : c - h;
      hi[k] = (c + h > COORD_MAX) ? COORD_MAX : c + h;
    end
    // occasional inverted axis
    if ($urandom_range(19) == 0) begin
      k     = $urandom_range(2);
      c     = lo[k];
      lo[k] = hi[k];
      hi[k] = c;
    end
    return mk_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
  endfunction

  task automatic set_idling(input int mix);
    case (mix)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
      default: begin send_idle_pct = 21; recv_stall_pct = 21; end
    endcase
  endtask

  // lower valid and hold off until every box has come back
  task automatic wait_drain();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic send_box(input box_t b);
    if (send_idle_pct != 0 && int'($urandom_range(99)) < send_idle_pct) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid     = 1'b1;
    in_box_min_x = b.min_x;
    in_box_min_y = b.min_y;
    in_box_min_z = b.min_z;
    in_box_max_x = b.max_x;
    in_box_max_y = b.max_y;
    in_box_max_z = b.max_z;
    do @(negedge clk); while (!in_fire);
    boxes_sent++;
  endtask

  task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                           input logic [CFG_DATA_WIDTH-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(negedge clk); while (!cfg_fire);
    cfg_valid = 1'b0;
  endtask

  // new matrix, only with the pipeline empty
  task automatic load_matrix(input logic [CFG_DATA_WIDTH-1:0] r0, r1, r2, r3);
    wait_drain();
    write_reg(REG_MATRIX_ROW0, r0);
    write_reg(REG_MATRIX_ROW1, r1);
    write_reg(REG_MATRIX_ROW2, r2);
    write_reg(REG_MATRIX_ROW3, r3);
    // write to an unmapped index must leave the rows alone
    write_reg(CFG_INDEX_WIDTH'($urandom_range(REG_UNMAPPED_LAST, REG_UNMAPPED_FIRST)),
              {$urandom, $urandom});
    settings_loaded++;
  endtask

  task automatic load_perspective(input int sx, sy, w, dn, amt);
    load_matrix(pack_row(sx + jitter(amt), jitter(amt), jitter(amt), jitter(amt)),
                pack_row(jitter(amt), sy + jitter(amt), jitter(amt), jitter(amt)),
                pack_row(jitter(amt), jitter(amt), w + w / 8 + jitter(amt), -dn + jitter(amt)),
                pack_row(jitter(amt), jitter(amt), w + jitter(amt), jitter(amt)));
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // zero matrix after reset, every box passes
    set_idling(0);
    send_box(mk_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
    send_box(mk_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN));
    send_box(mk_box(COORD_MIN, COORD_MAX, 0, COORD_MIN, COORD_MAX, 0));
    for (int i = 0; i < 40; i++) begin
      send_box(rand_box());
    end

    // exact perspective frustum: |x|,|y| <= z, z from about 9 to 80
    load_perspective(256, 256, 256, 2560, 0);
    send_box(mk_box(-5, -5, 20, 5, 5, 30));
    send_box(mk_box(-200, -5, 20, -100, 5, 30));
    send_box(mk_box(100, -5, 20, 200, 5, 30));
    send_box(mk_box(-5, -200, 20, 5, -100, 30));
    send_box(mk_box(-5, 100, 20, 5, 200, 30));
    send_box(mk_box(-5, -5, 0, 5, 5, 5));
    send_box(mk_box(-5, -5, 100, 5, 5, 200));
    send_box(mk_box(-5, -5, 0, 5, 5, 20));
    send_box(mk_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
    send_box(mk_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
    send_box(mk_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
    // inverted boxes, corners taken as given
    send_box(mk_box(5, 5, 30, -5, -5, 20));
    send_box(mk_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN));
    // point exactly on the right plane, then one step outside
    send_box(mk_box(20, 0, 20, 20, 0, 20));
    send_box(mk_box(21, 0, 20, 21, 0, 20));
    set_idling(3);
    for (int i = 0; i < 150; i++) begin
      send_box(rand_box());
    end

    // extreme, random and perturbed matrices
    for (int s = 0; s < NUM_RANDOM_SETTINGS; s++) begin
      case (s)
        0: load_matrix(pack_row(MAT_MAX, MAT_MAX, MAT_MAX, MAT_MAX),
                       pack_row(MAT_MAX, MAT_MAX, MAT_MAX, MAT_MAX),
                       pack_row(MAT_MAX, MAT_MAX, MAT_MAX, MAT_MAX),
                       pack_row(MAT_MAX, MAT_MAX, MAT_MAX, MAT_MAX));
        1: load_matrix(pack_row(MAT_MIN, MAT_MIN, MAT_MIN, MAT_MIN),
                       pack_row(MAT_MIN, MAT_MIN, MAT_MIN, MAT_MIN),
                       pack_row(MAT_MIN, MAT_MIN, MAT_MIN, MAT_MIN),
                       pack_row(MAT_MIN, MAT_MIN, MAT_MIN, MAT_MIN));
        2: load_matrix(pack_row(MAT_MIN, MAT_MIN, MAT_MIN, MAT_MIN),
                       pack_row(MAT_MIN, MAT_MIN, MAT_MIN, MAT_MIN),
                       pack_row(MAT_MIN, MAT_MIN, MAT_MIN, MAT_MIN),
                       pack_row(MAT_MAX, MAT_MAX, MAT_MAX, MAT_MAX));
        3, 5, 7: load_matrix({$urandom, $urandom}, {$urandom, $urandom},
                             {$urandom, $urandom}, {$urandom, $urandom});
        default: load_perspective($urandom_range(8, 2048), $urandom_range(8, 2048),
                                  $urandom_range(16, 1024), $urandom_range(8192), 8);
      endcase
      set_idling(s % 4);
      for (int i = 0; i < RANDOM_PER_SETTING; i++) begin
        if (i == RANDOM_PER_SETTING / 2 && s % 3 == 0) begin
          wait_drain();
        end
        send_box(rand_box());
      end
    end

    // let the pipeline empty, then idle on for strays
    wait_drain();
    repeat (8) @(negedge clk);

    $display("covered %0d boxes over %0d matrix settings (reset, perspective, extreme, random)",
             boxes_sent, settings_loaded);
    $display("results: %0d visible, %0d culled, %0d mismatches",
             visible_seen, culled_seen, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
